>>> sv/bjfc_pkg.sv
// Shared constants and types for the B-spline jerk and feasibility cost block.
`timescale 1ns / 1ps
package bjfc_pkg;

  localparam int POINT_LIMIT_DEF = 1024;
  localparam int SPLINE_ORDER    = 3;
  localparam int AXES            = 3;

  localparam logic [63:0] CAP63 = 64'h7FFF_FFFF_FFFF_FFFF;

  // multiplier shift amounts
  localparam int SHIFT_W = 6;
  localparam logic [SHIFT_W-1:0] SH_0  = 6'd0;
  localparam logic [SHIFT_W-1:0] SH_13 = 6'd13;
  localparam logic [SHIFT_W-1:0] SH_14 = 6'd14;
  localparam logic [SHIFT_W-1:0] SH_16 = 6'd16;
  localparam logic [SHIFT_W-1:0] SH_32 = 6'd32;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACC  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_W_SMOOTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_W_FEAS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd5;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RUN  = 5'b00010,
    ST_WAIT = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  // micro-program steps, one axis at a time
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] SP_V_SET  = 5'd0;
  localparam logic [STEP_W-1:0] SP_V_MM   = 5'd1;
  localparam logic [STEP_W-1:0] SP_V_S    = 5'd2;
  localparam logic [STEP_W-1:0] SP_V_X    = 5'd3;
  localparam logic [STEP_W-1:0] SP_V_Y    = 5'd4;
  localparam logic [STEP_W-1:0] SP_V_G    = 5'd5;
  localparam logic [STEP_W-1:0] SP_V_E    = 5'd6;
  localparam logic [STEP_W-1:0] SP_V_C    = 5'd7;
  localparam logic [STEP_W-1:0] SP_A_SET  = 5'd8;
  localparam logic [STEP_W-1:0] SP_A_R    = 5'd9;
  localparam logic [STEP_W-1:0] SP_A_S    = 5'd10;
  localparam logic [STEP_W-1:0] SP_A_I    = 5'd11;
  localparam logic [STEP_W-1:0] SP_A_P    = 5'd12;
  localparam logic [STEP_W-1:0] SP_A_U    = 5'd13;
  localparam logic [STEP_W-1:0] SP_A_G1   = 5'd14;
  localparam logic [STEP_W-1:0] SP_A_G2   = 5'd15;
  localparam logic [STEP_W-1:0] SP_A_E    = 5'd16;
  localparam logic [STEP_W-1:0] SP_A_C    = 5'd17;
  localparam logic [STEP_W-1:0] SP_J_SET  = 5'd18;
  localparam logic [STEP_W-1:0] SP_J_T2   = 5'd19;
  localparam logic [STEP_W-1:0] SP_J_T6   = 5'd20;
  localparam logic [STEP_W-1:0] SP_J_MM   = 5'd21;
  localparam logic [STEP_W-1:0] SP_J_C    = 5'd22;
  localparam logic [STEP_W-1:0] SP_AX_END = 5'd23;

  // output slots of one item
  localparam logic [1:0] SL_G0 = 2'd0;
  localparam logic [1:0] SL_G1 = 2'd1;
  localparam logic [1:0] SL_G2 = 2'd2;
  localparam logic [1:0] SL_GC = 2'd3;

endpackage

>>> sv/bjfc_mul.sv
// Iterative 64x64 multiplier with right shift and cap at 2^63-1, or in raw mode the low 64 bits unshifted.
`timescale 1ns / 1ps
module bjfc_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [63:0]                 a,
  input  logic [63:0]                 b,
  input  logic [bjfc_pkg::SHIFT_W-1:0] shift,
  input  logic                        raw,
  output logic                        done,
  output logic [63:0]                 result
);
  import bjfc_pkg::*;

  logic               run;
  logic [2:0]         k;
  logic               pv;
  logic [1:0]         pk;
  logic [63:0]        a_r, b_r;
  logic [SHIFT_W-1:0] sh_r;
  logic               raw_r;
  logic [63:0]        pp;
  logic [127:0]       acc, acc_add, shifted;
  logic [31:0]        a_half, b_half;

  // one 32x32 partial product per cycle, k[1] picks the half of a, k[0] of b
  assign a_half  = k[1] ? a_r[63:32] : a_r[31:0];
  assign b_half  = k[0] ? b_r[63:32] : b_r[31:0];
  assign shifted = acc >> sh_r;

  always_comb begin
    case (pk)
      2'd0:    acc_add = {64'd0, pp};
      2'd3:    acc_add = {pp, 64'd0};
      default: acc_add = {32'd0, pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      pv   <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        k   <= '0;
        pv  <= 1'b0;
      end else if (run) begin
        pv <= (k < 3'd4);
        k  <= k + 3'd1;
        if (k == 3'd5) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      sh_r  <= shift;
      raw_r <= raw;
      acc   <= '0;
    end else if (run) begin
      if (k < 3'd4) begin
        pp <= a_half * b_half;
        pk <= k[1:0];
      end
      if (pv) acc <= acc + acc_add;
      if (k == 3'd5) begin
        if (raw_r) result <= acc[63:0];
        else if (|shifted[127:63]) result <= CAP63;
        else result <= {1'b0, shifted[62:0]};
      end
    end
  end

endmodule

>>> sv/bspline_jerk_feasibility_cost_core.sv
// Jerk smoothness and feasibility cost of a cubic B-spline control polygon.
//
// Control points enter on the in channel (in_valid/in_ready), one word per point.
// in_ready is high only while the block is idle; a point is worked through one
// axis at a time by a sequencer driving one shared iterative multiplier.
// Each multiply step runs issue, 4 partial products, accumulate, shift/cap and
// writeback in order; an axis has up to 20 multiply steps plus its sequencing
// steps (three term checks and the axis end).
// Each point gives 0 or 1 gradient words on the out channel, a last point gives
// 1 to 4 words, the final one carrying total_cost and last_result.
// Results wait in an output register; a stalled receiver holds the sequencer in
// its emit phase but the register holds the word stable.
// The cfg channel is always ready and writes one register per word; write only
// while idle. Synchronous reset clears the point window, pending gradients,
// cost and count, and returns registers to their defaults.
`timescale 1ns / 1ps
module bspline_jerk_feasibility_cost_core #(
  parameter int POINT_LIMIT = bjfc_pkg::POINT_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            pos_x,
  input  logic signed [31:0]            pos_y,
  input  logic signed [31:0]            pos_z,
  input  logic                          last_point,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [63:0]            grad_x,
  output logic signed [63:0]            grad_y,
  output logic signed [63:0]            grad_z,
  output logic [9:0]                    point_index,
  output logic [62:0]                   total_cost,
  output logic                          last_result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bjfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import bjfc_pkg::*;

  localparam int CNT_W = $clog2(POINT_LIMIT);
  localparam int IDX_W = (CNT_W > 10) ? CNT_W : 10;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] acc_in,
                                                 input logic [63:0] mag,
                                                 input logic ng);
    logic signed [64:0] bv;
    logic signed [64:0] s;
    bv = ng ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    s  = $signed({acc_in[63], acc_in}) + bv;
    if (s[64] != s[63]) sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else sat_add = s[63:0];
  endfunction

  // configuration
  logic [31:0] inv, max_vel, max_acc, w_smooth, w_feas;
  logic [1:0]  cen;

  // item state
  state_t             state;
  logic [STEP_W-1:0]  step;
  logic [1:0]         ax;
  logic [1:0]         slot;
  logic signed [31:0] cur [AXES];
  logic               last_r;
  logic signed [31:0] p [SPLINE_ORDER][AXES];
  logic signed [63:0] g [SPLINE_ORDER][AXES];
  logic signed [63:0] gc [AXES];
  logic [62:0]        cost_sum;
  logic [CNT_W-1:0]   cnt;
  logic [34:0]        m;
  logic               neg;
  logic [63:0]        t, d;

  // datapath signals
  logic signed [35:0] cur_e, p0_e, p1_e, p2_e, diff, diff_abs;
  logic [63:0]        m64, lim_v, lim_a, cost_next;
  logic               mul_start, mul_done;
  logic [63:0]        mul_a, mul_b, r;
  logic [SHIFT_W-1:0] mul_sh;
  logic               mul_raw;
  logic               out_free, slot_exists;
  logic [CNT_W-1:0]   back;
  logic [IDX_W-1:0]   idx_w;

  assign cur_e = 36'(cur[ax]);
  assign p0_e  = 36'(p[0][ax]);
  assign p1_e  = 36'(p[1][ax]);
  assign p2_e  = 36'(p[2][ax]);

  always_comb begin
    case (step)
      SP_V_SET: diff = cur_e - p2_e;
      SP_A_SET: diff = cur_e - (p2_e <<< 1) + p1_e;
      default:  diff = cur_e - p2_e - (p2_e <<< 1) + p1_e + (p1_e <<< 1) - p0_e;
    endcase
  end
  assign diff_abs = diff[35] ? -diff : diff;

  assign m64       = 64'(m);
  assign lim_v     = {16'd0, max_vel, 16'd0};
  assign lim_a     = {16'd0, max_acc, 16'd0};
  assign cost_next = 64'(cost_sum) + r;

  // operand selection for the shared multiplier
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_sh  = SH_0;
    mul_raw = 1'b0;
    case (step)
      SP_V_MM: begin mul_a = m64;            mul_b = m64;            mul_raw = 1'b1; end
      SP_V_S:  begin mul_a = t;              mul_b = 64'(inv);       mul_sh = SH_16; end
      SP_V_X:  begin mul_a = d;              mul_b = 64'(inv);       mul_sh = SH_16; end
      SP_V_Y:  begin mul_a = t;              mul_b = m64;            mul_sh = SH_16; end
      SP_V_G:  begin mul_a = 64'(w_feas);    mul_b = t;              mul_sh = SH_14; end
      SP_V_E:  begin mul_a = d;              mul_b = d;              mul_sh = SH_32; end
      SP_V_C:  begin mul_a = 64'(w_feas);    mul_b = t;              mul_sh = SH_16; end
      SP_A_R:  begin mul_a = m64;            mul_b = 64'(inv);       mul_sh = SH_16; end
      SP_A_S:  begin mul_a = t;              mul_b = t;              mul_sh = SH_0;  end
      SP_A_I:  begin mul_a = 64'(inv);       mul_b = 64'(inv);       mul_raw = 1'b1; end
      SP_A_P:  begin mul_a = d;              mul_b = t;              mul_sh = SH_32; end
      SP_A_U:  begin mul_a = t;              mul_b = m64;            mul_sh = SH_16; end
      SP_A_G1: begin mul_a = 64'(w_feas);    mul_b = t;              mul_sh = SH_14; end
      SP_A_G2: begin mul_a = 64'(w_feas);    mul_b = t;              mul_sh = SH_13; end
      SP_A_E:  begin mul_a = d;              mul_b = d;              mul_sh = SH_32; end
      SP_A_C:  begin mul_a = 64'(w_feas);    mul_b = t;              mul_sh = SH_16; end
      SP_J_T2: begin mul_a = 64'(w_smooth);  mul_b = m64 << 1;       mul_sh = SH_0;  end
      SP_J_T6: begin mul_a = 64'(w_smooth);  mul_b = (m64 << 2) + (m64 << 1); end
      SP_J_MM: begin mul_a = m64;            mul_b = m64;            mul_sh = SH_0;  end
      SP_J_C:  begin mul_a = 64'(w_smooth);  mul_b = t;              mul_sh = SH_16; end
      default: ;
    endcase
  end

  always_comb begin
    case (step)
      SP_V_SET, SP_A_SET, SP_J_SET, SP_AX_END: mul_start = 1'b0;
      default: mul_start = (state == ST_RUN);
    endcase
  end

  bjfc_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .shift  (mul_sh),
    .raw    (mul_raw),
    .done   (mul_done),
    .result (r)
  );

  // emit slots: oldest point first, current point last
  always_comb begin
    case (slot)
      SL_G0:   begin slot_exists = (cnt >= CNT_W'(3)); back = CNT_W'(3); end
      SL_G1:   begin slot_exists = (cnt >= CNT_W'(2)); back = CNT_W'(2); end
      SL_G2:   begin slot_exists = (cnt != '0);        back = CNT_W'(1); end
      default: begin slot_exists = 1'b1;               back = '0;        end
    endcase
  end
  assign idx_w    = IDX_W'(cnt - back);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv      <= 32'd65536;
      max_vel  <= 32'd65536;
      max_acc  <= 32'd65536;
      w_smooth <= 32'd65536;
      w_feas   <= 32'd65536;
      cen      <= 2'd3;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_INV:      inv      <= cfg_data;
        CFG_MAX_VEL:  max_vel  <= cfg_data;
        CFG_MAX_ACC:  max_acc  <= cfg_data;
        CFG_W_SMOOTH: w_smooth <= cfg_data;
        CFG_W_FEAS:   w_feas   <= cfg_data;
        CFG_ENABLE:   cen      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= SP_V_SET;
      ax        <= '0;
      slot      <= SL_G0;
      out_valid <= 1'b0;
      cost_sum  <= '0;
      cnt       <= '0;
      for (int k = 0; k < SPLINE_ORDER; k++) begin
        for (int a = 0; a < AXES; a++) begin
          p[k][a] <= '0;
          g[k][a] <= '0;
        end
      end
    end else begin
      // a new word loaded in the emit phase keeps out_valid high
      if (out_valid && out_ready && !(state == ST_EMIT && slot_exists)) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cur[0] <= pos_x;
            cur[1] <= pos_y;
            cur[2] <= pos_z;
            last_r <= last_point;
            for (int a = 0; a < AXES; a++) gc[a] <= '0;
            ax    <= '0;
            step  <= SP_V_SET;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          case (step)
            SP_V_SET: begin
              if (cen[1] && cnt != '0) begin
                m    <= diff_abs[34:0];
                neg  <= diff[35];
                step <= SP_V_MM;
              end else step <= SP_A_SET;
            end
            SP_A_SET: begin
              if (cen[1] && cnt >= CNT_W'(2)) begin
                m    <= diff_abs[34:0];
                neg  <= diff[35];
                step <= SP_A_R;
              end else step <= SP_J_SET;
            end
            SP_J_SET: begin
              if (cen[0] && cnt >= CNT_W'(3)) begin
                m    <= diff_abs[34:0];
                neg  <= diff[35];
                step <= SP_J_T2;
              end else step <= SP_AX_END;
            end
            SP_AX_END: begin
              if (ax == 2'd2) begin
                slot  <= SL_G0;
                state <= ST_EMIT;
              end else begin
                ax   <= ax + 2'd1;
                step <= SP_V_SET;
              end
            end
            default: state <= ST_WAIT;
          endcase
        end
        ST_WAIT: begin
          if (mul_done) begin
            state <= ST_RUN;
            // the limit compares pick their own next step
            if (step != SP_V_S && step != SP_A_S) step <= step + 5'd1;
            case (step)
              SP_V_S: begin
                if (r > lim_v) begin
                  d    <= r - lim_v;
                  step <= SP_V_X;
                end else step <= SP_A_SET;
              end
              SP_A_S: begin
                if (r > lim_a) begin
                  d    <= r - lim_a;
                  step <= SP_A_I;
                end else step <= SP_J_SET;
              end
              SP_V_G: begin
                g[2][ax] <= sat_add(g[2][ax], r, !neg);
                gc[ax]   <= sat_add(gc[ax], r, neg);
              end
              SP_A_G1: begin
                g[1][ax] <= sat_add(g[1][ax], r, neg);
                gc[ax]   <= sat_add(gc[ax], r, neg);
              end
              SP_A_G2: g[2][ax] <= sat_add(g[2][ax], r, !neg);
              SP_J_T2: begin
                g[0][ax] <= sat_add(g[0][ax], r, !neg);
                gc[ax]   <= sat_add(gc[ax], r, neg);
              end
              SP_J_T6: begin
                g[1][ax] <= sat_add(g[1][ax], r, neg);
                g[2][ax] <= sat_add(g[2][ax], r, !neg);
              end
              SP_V_C, SP_A_C, SP_J_C:
                cost_sum <= cost_next[63] ? CAP63[62:0] : cost_next[62:0];
              default: t <= r;
            endcase
          end
        end
        ST_EMIT: begin
          if (!slot_exists || out_free) begin
            if (slot_exists) begin
              out_valid   <= 1'b1;
              point_index <= idx_w[9:0];
              last_result <= (slot == SL_GC);
              total_cost  <= (slot == SL_GC) ? cost_sum : '0;
              case (slot)
                SL_G0: begin grad_x <= g[0][0]; grad_y <= g[0][1]; grad_z <= g[0][2]; end
                SL_G1: begin grad_x <= g[1][0]; grad_y <= g[1][1]; grad_z <= g[1][2]; end
                SL_G2: begin grad_x <= g[2][0]; grad_y <= g[2][1]; grad_z <= g[2][2]; end
                default: begin grad_x <= gc[0]; grad_y <= gc[1]; grad_z <= gc[2]; end
              endcase
            end
            if ((slot == SL_G0 && !last_r) || slot == SL_GC) state <= ST_FIN;
            else slot <= slot + 2'd1;
          end
        end
        ST_FIN: begin
          if (last_r) begin
            cost_sum <= '0;
            cnt      <= '0;
            for (int k = 0; k < SPLINE_ORDER; k++) begin
              for (int a = 0; a < AXES; a++) begin
                p[k][a] <= '0;
                g[k][a] <= '0;
              end
            end
          end else begin
            for (int a = 0; a < AXES; a++) begin
              p[0][a] <= p[1][a];
              p[1][a] <= p[2][a];
              p[2][a] <= cur[a];
              g[0][a] <= g[1][a];
              g[1][a] <= g[2][a];
              g[2][a] <= gc[a];
            end
            if (cnt < CNT_W'(POINT_LIMIT - 1)) cnt <= cnt + CNT_W'(1);
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> sv/bjfc_chk.sv
// Port-level checks for the cost core, bound to the top level.
`timescale 1ns / 1ps
module bjfc_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] grad_x,
  input logic [62:0] total_cost,
  input logic        last_result
);

  // after a word is taken, in_ready is low in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an accepted word");

  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  a_cost_only_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_result |-> total_cost == '0)
    else $error("nonzero total_cost on a non-final word");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(grad_x) && $stable(last_result))
    else $error("output word changed while stalled");

endmodule

bind bspline_jerk_feasibility_cost_core bjfc_chk u_bjfc_chk (.*);

>>> sim/bspline_jerk_feasibility_cost_core_tb.sv
// Self-checking testbench for the B-spline jerk and feasibility cost core.
`timescale 1ns / 1ps
module bspline_jerk_feasibility_cost_core_tb;
  import bjfc_pkg::*;

  localparam logic [63:0] SAT_HI = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [63:0] gx;
    logic signed [63:0] gy;
    logic signed [63:0] gz;
    logic [9:0]         idx;
    logic [62:0]        cost;
    logic               last;
  } grad_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic last_point = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [63:0] grad_x, grad_y, grad_z;
  logic [9:0] point_index;
  logic [62:0] total_cost;
  logic last_result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  bspline_jerk_feasibility_cost_core dut (.*);

  always #4 clk = ~clk;

  // predictor state
  logic [63:0] inv_sq, vel_lim, acc_lim, w_smooth, w_feas;
  logic [1:0]  enables;
  logic signed [63:0] win [3][3];
  logic signed [63:0] pend [3][3];
  logic [63:0] cost_acc;
  int unsigned npts;

  grad_word_t expected_grads[$];
  int mismatches = 0;
  int idle_pct = 29;
  bit rx_hold = 1'b0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;

  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = (a * 128'd1 * b) >> s;
    return (p > {64'd0, SAT_HI}) ? SAT_HI : p[63:0];
  endfunction

  function automatic logic signed [63:0] sat_add(logic signed [63:0] acc,
                                                 logic [63:0] mag, bit neg);
    logic signed [65:0] sum;
    sum = {{2{acc[63]}}, acc} + (neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag}));
    if (sum > $signed({3'b000, SAT_HI})) return $signed(SAT_HI);
    if (sum < -$signed({3'b000, SAT_HI}) - 1) return $signed(~SAT_HI);
    return sum[63:0];
  endfunction

  function automatic void add_cost(logic [63:0] c);
    cost_acc = (c > SAT_HI - cost_acc) ? SAT_HI : cost_acc + c;
  endfunction

  function automatic logic [63:0] mag_of(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void reset_predictor();
    inv_sq = 65536; vel_lim = 65536; acc_lim = 65536;
    w_smooth = 65536; w_feas = 65536; enables = 2'b11;
  endfunction

  function automatic void clear_polygon();
    for (int i = 0; i < 3; i++)
      for (int a = 0; a < 3; a++) begin
        win[i][a] = 0; pend[i][a] = 0;
      end
    cost_acc = 0; npts = 0;
  endfunction

  function automatic void push_grad(logic signed [63:0] g[3], int unsigned idx, bit last);
    grad_word_t w;
    w.gx = g[0]; w.gy = g[1]; w.gz = g[2];
    w.idx = idx[9:0];
    w.cost = last ? cost_acc[62:0] : '0;
    w.last = last;
    expected_grads = {expected_grads, w};
  endfunction

  function automatic void predict_point(logic signed [31:0] px, logic signed [31:0] py,
                                        logic signed [31:0] pz, bit lastp);
    logic signed [63:0] cur[3], gcur[3], v, acc, jk;
    logic [63:0] m, s, lim, d, gm, r, u, g1, g2, t2, t6;
    cur[0] = px; cur[1] = py; cur[2] = pz;
    for (int a = 0; a < 3; a++) gcur[a] = 0;
    for (int a = 0; a < 3; a++) begin
      if (enables[1] && npts >= 1) begin
        v = cur[a] - win[2][a];
        m = mag_of(v);
        s = mul_shift(m * m, inv_sq, 16);
        lim = vel_lim << 16;
        if (s > lim) begin
          d = s - lim;
          gm = mul_shift(w_feas, mul_shift(mul_shift(d, inv_sq, 16), m, 16), 14);
          add_cost(mul_shift(w_feas, mul_shift(d, d, 32), 16));
          pend[2][a] = sat_add(pend[2][a], gm, v >= 0);
          gcur[a] = sat_add(gcur[a], gm, v < 0);
        end
      end
      if (enables[1] && npts >= 2) begin
        acc = cur[a] - 2 * win[2][a] + win[1][a];
        m = mag_of(acc);
        r = mul_shift(m, inv_sq, 16);
        s = mul_shift(r, r, 0);
        lim = acc_lim << 16;
        if (s > lim) begin
          d = s - lim;
          u = mul_shift(mul_shift(d, inv_sq * inv_sq, 32), m, 16);
          g1 = mul_shift(w_feas, u, 14);
          g2 = mul_shift(w_feas, u, 13);
          add_cost(mul_shift(w_feas, mul_shift(d, d, 32), 16));
          pend[1][a] = sat_add(pend[1][a], g1, acc < 0);
          pend[2][a] = sat_add(pend[2][a], g2, !(acc < 0));
          gcur[a] = sat_add(gcur[a], g1, acc < 0);
        end
      end
      if (enables[0] && npts >= 3) begin
        jk = cur[a] - 3 * win[2][a] + 3 * win[1][a] - win[0][a];
        m = mag_of(jk);
        t2 = mul_shift(w_smooth, 2 * m, 0);
        t6 = mul_shift(w_smooth, 6 * m, 0);
        add_cost(mul_shift(w_smooth, mul_shift(m, m, 0), 16));
        pend[0][a] = sat_add(pend[0][a], t2, !(jk < 0));
        pend[1][a] = sat_add(pend[1][a], t6, jk < 0);
        pend[2][a] = sat_add(pend[2][a], t6, !(jk < 0));
        gcur[a] = sat_add(gcur[a], t2, jk < 0);
      end
    end
    if (npts >= 3) push_grad(pend[0], npts - 3, 1'b0);
    if (lastp) begin
      if (npts >= 2) push_grad(pend[1], npts - 2, 1'b0);
      if (npts >= 1) push_grad(pend[2], npts - 1, 1'b0);
      push_grad(gcur, npts, 1'b1);
      clear_polygon();
    end else begin
      for (int k = 0; k < 2; k++) begin
        win[k] = win[k + 1]; pend[k] = pend[k + 1];
      end
      win[2] = cur; pend[2] = gcur;
      if (npts < 1023) npts++;
    end
  endfunction

  // valid stays up between back-to-back words; drain and idle cycles drop it
  task automatic send_point(logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] pz, bit lastp);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x <= px; pos_y <= py; pos_z <= pz; last_point <= lastp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_point(px, py, pz, lastp);
  endtask

  // cfg_valid is dropped by the next send or drain
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_INV:      inv_sq = val;
      CFG_MAX_VEL:  vel_lim = val;
      CFG_MAX_ACC:  acc_lim = val;
      CFG_W_SMOOTH: w_smooth = val;
      CFG_W_FEAS:   w_feas = val;
      CFG_ENABLE:   enables = val[1:0];
      default: ;
    endcase
  endtask

  // every polygon ends on a last point, so an empty queue means idle
  task automatic drain();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (expected_grads.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $signed($urandom);
      1: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
      default: return $signed($urandom_range(0, 32'h007F_FFFF)) - 32'sh0040_0000;
    endcase
  endfunction

  task automatic send_polygon(int len, int mode);
    for (int i = 0; i < len; i++)
      send_point(rand_coord(mode), rand_coord(mode), rand_coord(mode), i == len - 1);
  endtask

  task automatic test_short_polygons();
    for (int len = 1; len <= 5; len++) send_polygon(len, 1);
    drain();
  endtask

  task automatic test_extremes();
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1'b0);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, -1, 1'b0);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 1, 1'b0);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    send_point(0, 0, 32'sh8000_0000, 1'b1);
    send_point(0, 0, 0, 1'b0);
    send_point(0, 0, 0, 1'b0);
    send_point(0, 0, 0, 1'b1);
    drain();
  endtask

  task automatic test_register_sweep();
    logic [31:0] vals[4];
    vals[0] = 0; vals[1] = 32'hFFFF_FFFF; vals[2] = 32'h0000_4000; vals[3] = 32'h0004_0000;
    for (int e = 0; e < 4; e++) begin
      write_reg(CFG_ENABLE, 32'(e));
      for (int r = 0; r < 4; r++) begin
        write_reg(CFG_INV, vals[r]);
        write_reg(CFG_MAX_VEL, vals[(r + 1) % 4]);
        write_reg(CFG_MAX_ACC, vals[(r + 2) % 4]);
        write_reg(CFG_W_SMOOTH, vals[(r + 3) % 4]);
        write_reg(CFG_W_FEAS, vals[r]);
        send_polygon($urandom_range(4, 7), $urandom_range(0, 2));
        drain();
      end
    end
    reset_predictor_regs();
  endtask

  task automatic reset_predictor_regs();
    write_reg(CFG_INV, 65536); write_reg(CFG_MAX_VEL, 65536);
    write_reg(CFG_MAX_ACC, 65536); write_reg(CFG_W_SMOOTH, 65536);
    write_reg(CFG_W_FEAS, 65536); write_reg(CFG_ENABLE, 3);
  endtask

  task automatic test_backpressure();
    fork
      begin
        rx_hold = 1'b1;
        repeat (3000) @(posedge clk);
        rx_hold = 1'b0;
      end
      send_polygon(12, 2);
    join
    drain();
  endtask

  task automatic test_random();
    int sent = 0;
    int len;
    while (sent < 280) begin
      if (sent > 80 && sent < 200) idle_pct = 0;
      else idle_pct = 29;
      if ($urandom_range(9) == 0) begin
        drain();
        write_reg(CFG_INV, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 32'h4_0000));
        write_reg(CFG_MAX_VEL, $urandom_range(0, 32'h8_0000));
        write_reg(CFG_MAX_ACC, $urandom_range(0, 32'h8_0000));
        write_reg(CFG_ENABLE, $urandom_range(0, 3));
      end
      len = ($urandom_range(19) == 0) ? 1 : $urandom_range(2, 12);
      send_polygon(len, $urandom_range(0, 2));
      sent += len;
    end
    idle_pct = 29;
    drain();
  endtask

  // receiver ready
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !rx_hold && ($urandom_range(99) >= idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    grad_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_grads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected gradient word idx=%0d", point_index);
      end else begin
        want = expected_grads.pop_front();
        if (grad_x !== want.gx || grad_y !== want.gy || grad_z !== want.gz ||
            point_index !== want.idx || total_cost !== want.cost ||
            last_result !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp g=%h/%h/%h idx=%0d cost=%h last=%b",
                     want.gx, want.gy, want.gz, want.idx, want.cost, want.last);
            $display("          got g=%h/%h/%h idx=%0d cost=%h last=%b",
                     grad_x, grad_y, grad_z, point_index, total_cost, last_result);
          end
        end
      end
    end
  end

  // watchdog: cycles with no word moved on any channel, outside a receiver hold
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rx_hold)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
    end
  end

  initial begin
    reset_predictor();
    clear_polygon();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    fork
      begin
        test_short_polygons();
        test_extremes();
        test_register_sweep();
        test_backpressure();
        test_random();
      end
      wait (timed_out);
    join_any
    if (timed_out) begin
      $display("[FAIL] regression broken");
    end else if (mismatches == 0 && expected_grads.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
